// ===== rtl/cic_decimator_defines.svh =====
// Assertion macros shared by the RTL of the CIC decimator.
`ifndef CIC_DECIMATOR_DEFINES_SVH
`define CIC_DECIMATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define CICD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define CICD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cicd_pkg.sv =====
package cicd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int ACC_W    = 14;
  localparam int DELAY_W  = 3;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [DELAY_W-1:0]       delay_t;

  // top bit flip turns offset binary into two's complement
  localparam sample_t SIGN_FLIP   = sample_t'(8'h80);
  localparam delay_t  DELAY_RESET = delay_t'(3'd4);

  // register index, taken from the word address
  localparam logic REG_DIFF_DELAY = 1'b0;

endpackage

// ===== rtl/cicd_in_if.sv =====
interface cicd_in_if;
  logic              valid;
  logic              ready;
  cicd_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/cicd_out_if.sv =====
interface cicd_out_if;
  logic           valid;
  logic           ready;
  cicd_pkg::acc_t comb_out;

  modport source (output valid, output comb_out, input ready);
  modport sink   (input valid, input comb_out, output ready);
endinterface

// ===== rtl/cic_decimator.sv =====
// Single-stage CIC decimator: offset-binary 8-bit samples come in on sample_i,
// one per clock, and every DECIMATION-th sample yields a 14-bit two's
// complement result on result_o. The integrator wraps at 14 bits and adds
// each sample as it is taken; on the decimating sample the new integrator
// value is written into a small synchronous delay-line RAM while the entry
// diff_delay slots back is read into the read stage; from there the comb
// difference moves into the output register once that register is empty or
// its result is taken, and the result is offered on result_o. The block
// takes one request per cycle; only a decimating request waits, and only
// while a finished result still sits in the output register and the next one
// is held in the read stage behind it.
// diff_delay (APB address 0, reset 4) is clamped to 1..MAX_DELAY and takes
// effect on the next decimating sample. Delay-line entries carry flip-flop
// valid bits cleared by reset, so no clearing pass is needed after reset.
`include "cic_decimator_defines.svh"

module cic_decimator #(
  parameter int DECIMATION = 16,
  parameter int MAX_DELAY  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cicd_in_if.sink                      sample_i,
  cicd_out_if.source                   result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cicd_pkg::APB_AW-1:0]  paddr,
  input  logic [cicd_pkg::APB_DW-1:0]  pwdata,
  output logic [cicd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int PHW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int PW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DW  = $clog2(MAX_DELAY + 1);
  localparam int CW  = (DW > cicd_pkg::DELAY_W) ? DW : cicd_pkg::DELAY_W;
  localparam int AW  = cicd_pkg::ACC_W;

  // configuration: wide enough for every delay up to MAX_DELAY
  logic [CW-1:0]    dly_q;
  logic             cfg_wr;

  // datapath state
  logic [AW-1:0]    integ_q, integ_d;
  logic [PHW-1:0]   phase_q, phase_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [MAX_DELAY-1:0] vld_q;

  // read stage
  logic             pend_q;
  logic [AW-1:0]    pend_integ_q;
  logic [AW-1:0]    rdata_q;
  logic             rd_vld_q;

  // output register
  logic             out_vld_q;
  logic [AW-1:0]    out_data_q;

  // delay line
  logic [AW-1:0]    mem [MAX_DELAY];

  logic             in_acc;
  logic             last_phase;
  logic             event_acc;
  logic             pend_move;
  logic [AW-1:0]    samp_ext;
  logic [CW-1:0]    d_raw, d_eff, ptr_ext, rd_w;
  logic [PW-1:0]    rd_idx;
  logic [AW-1:0]    old_val;

  // APB: zero-wait writes, register at word index 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cicd_pkg::REG_DIFF_DELAY)
                  ? cicd_pkg::APB_DW'(dly_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= CW'(cicd_pkg::DELAY_RESET);
    end else if (cfg_wr && (paddr[2] == cicd_pkg::REG_DIFF_DELAY)) begin
      dly_q <= pwdata[CW-1:0];
    end
  end

  // handshake: only the decimating request can be held back
  assign last_phase = (phase_q == PHW'(DECIMATION - 1));
  assign pend_move  = pend_q && (!out_vld_q || result_o.ready);
  assign sample_i.ready = !(last_phase && pend_q && !pend_move);
  assign in_acc     = sample_i.valid && sample_i.ready;
  assign event_acc  = in_acc && last_phase;

  // integrate the signed sample
  always_comb begin
    logic [cicd_pkg::SAMPLE_W-1:0] s;
    s        = sample_i.sample ^ cicd_pkg::SIGN_FLIP;
    samp_ext = {{(AW - cicd_pkg::SAMPLE_W){s[cicd_pkg::SAMPLE_W-1]}}, s};
    integ_d  = integ_q + samp_ext;
  end

  assign phase_d = last_phase ? '0 : phase_q + 1'b1;
  assign ptr_d   = (ptr_q == PW'(MAX_DELAY - 1)) ? '0 : ptr_q + 1'b1;

  // clamp the delay to 1..MAX_DELAY and find the slot it points back to
  always_comb begin
    d_raw = CW'(dly_q);
    if (d_raw == '0) begin
      d_eff = CW'(1);
    end else if (d_raw > CW'(MAX_DELAY)) begin
      d_eff = CW'(MAX_DELAY);
    end else begin
      d_eff = d_raw;
    end
    ptr_ext = CW'(ptr_q);
    if (ptr_ext >= d_eff) begin
      rd_w = ptr_ext - d_eff;
    end else begin
      rd_w = ptr_ext + CW'(MAX_DELAY) - d_eff;
    end
    rd_idx = rd_w[PW-1:0];
  end

  // delay-line RAM: read before write on the same slot at full delay
  always_ff @(posedge clk_i) begin
    if (event_acc) begin
      mem[ptr_q] <= integ_d;
      rdata_q    <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (event_acc) begin
      pend_integ_q <= integ_d;
    end
    if (pend_move) begin
      out_data_q <= pend_integ_q - old_val;
    end
  end

  // an entry never written reads as zero
  assign old_val = rd_vld_q ? rdata_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      phase_q   <= '0;
      ptr_q     <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        integ_q <= integ_d;
        phase_q <= phase_d;
      end
      if (event_acc) begin
        ptr_q         <= ptr_d;
        vld_q[ptr_q]  <= 1'b1;
        rd_vld_q      <= vld_q[rd_idx];
        pend_q        <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end
      // load the output stage, or drop the result once taken
      if (pend_move) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign result_o.valid    = out_vld_q;
  assign result_o.comb_out = cicd_pkg::acc_t'(out_data_q);

  `CICD_ASSERT_NOW(a_no_overrun, event_acc && pend_q, pend_move, "read stage overrun")
  `CICD_ASSERT_NEXT(a_event_pends, event_acc, pend_q, "decimating request lost")
  `CICD_ASSERT_NEXT(a_move_loads, pend_move, out_vld_q, "result not loaded")
  `CICD_ASSERT_NEXT(a_ptr_hold, !event_acc, $stable(ptr_q), "pointer moved without event")

endmodule
